// ===== hw/rtl/sacl_pkg.sv =====
// Shared types, constants and helpers of the set-associative cache LRU tag store.
package sacl_pkg;

  localparam int unsigned TagW          = 62;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned CntW          = 32;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 4;
  localparam int unsigned MaxSetBitsDef = 6;
  localparam int unsigned MaxWaysDef    = 8;

  localparam logic [2:0] SetBitsRst    = 3'd4;
  localparam logic [3:0] WaysInUseRst  = 4'd1;
  localparam logic [3:0] OffsetBitsRst = 4'd4;

  typedef enum logic [1:0] {
    ActLoad   = 2'd0,
    ActStore  = 2'd1,
    ActModify = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSetBits    = 2'd0,
    CfgWaysInUse  = 2'd1,
    CfgOffsetBits = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup
  } state_e;

  typedef struct packed {
    action_e          action;
    logic [AddrW-1:0] address;
  } cmd_t;

  typedef struct packed {
    logic            was_hit;
    logic            was_miss;
    logic            was_eviction;
    logic            second_hit;
    logic [CntW-1:0] total_hits;
    logic [CntW-1:0] total_misses;
    logic [CntW-1:0] total_evictions;
  } result_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
    logic second;
    logic wr_en;
  } acc_flags_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + CntW'(1);
  endfunction

endpackage

// ===== hw/rtl/sacl_row_mem.sv =====
// Set row memory: one write port, one read port, registered read data.
module sacl_row_mem #(
  parameter int unsigned AddrBits = 6,
  parameter int unsigned DataW    = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataW-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataW-1:0]    rdata_o
);

  localparam int unsigned Depth = 2 ** AddrBits;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sacl_way_logic.sv =====
// Way compare, victim choice and recency update for one set row.
module sacl_way_logic #(
  parameter int unsigned MaxWays = 8,
  parameter int unsigned WayW    = 3,
  parameter int unsigned RecW    = 3
) (
  input  sacl_pkg::action_e                       action_i,
  input  logic [3:0]                              ways_in_use_i,
  input  logic [sacl_pkg::TagW-1:0]               tag_i,
  input  logic [MaxWays-1:0]                      valid_i,
  input  logic [MaxWays-1:0][sacl_pkg::TagW-1:0]  tags_i,
  input  logic [MaxWays-1:0][RecW-1:0]            rec_i,
  output logic [MaxWays-1:0]                      valid_o,
  output logic [MaxWays-1:0][sacl_pkg::TagW-1:0]  tags_o,
  output logic [MaxWays-1:0][RecW-1:0]            rec_o,
  output sacl_pkg::acc_flags_t                    flags_o
);

  localparam logic [RecW-1:0] RecMax = RecW'(MaxWays - 1);

  logic [MaxWays-1:0] active;
  logic [MaxWays-1:0] hit_vec;
  logic [MaxWays-1:0] inv_vec;
  logic               any_hit;
  logic               any_inv;
  logic               act_ok;
  logic               filled;
  logic [WayW-1:0]    hit_way;
  logic [WayW-1:0]    inv_way;
  logic [WayW-1:0]    vic_way;
  logic [RecW-1:0]    vic_rec;
  logic [WayW-1:0]    sel_way;
  logic [RecW-1:0]    old_rec;

  // Classify the ways of the set.
  always_comb begin
    for (int i = 0; i < MaxWays; i++) begin
      if (ways_in_use_i == 4'd0) begin
        active[i] = (i == 0);
      end else begin
        active[i] = (32'(i) < 32'(ways_in_use_i));
      end
      hit_vec[i] = active[i] && valid_i[i] && (tags_i[i] == tag_i);
      inv_vec[i] = active[i] && !valid_i[i];
    end
  end

  // Pick hit way, first free way and LRU victim, lowest index on ties.
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int i = MaxWays - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WayW'(i);
      end
      if (inv_vec[i]) begin
        inv_way = WayW'(i);
      end
    end
    vic_way = '0;
    vic_rec = rec_i[0];
    for (int i = 1; i < MaxWays; i++) begin
      if (active[i] && (rec_i[i] > vic_rec)) begin
        vic_rec = rec_i[i];
        vic_way = WayW'(i);
      end
    end
  end

  assign any_hit = |hit_vec;
  assign any_inv = |inv_vec;
  assign act_ok  = (action_i != sacl_pkg::ActNone);
  assign filled  = !any_hit && any_inv;
  assign sel_way = any_hit ? hit_way : (any_inv ? inv_way : vic_way);
  assign old_rec = rec_i[sel_way];

  // Age the valid ways newer than the touched one (all on a fill), then make it most recent.
  always_comb begin
    valid_o = valid_i;
    tags_o  = tags_i;
    rec_o   = rec_i;
    for (int i = 0; i < MaxWays; i++) begin
      if ((WayW'(i) != sel_way) && valid_i[i] && active[i] &&
          (filled || (rec_i[i] < old_rec)) && (rec_i[i] < RecMax)) begin
        rec_o[i] = rec_i[i] + RecW'(1);
      end
    end
    rec_o[sel_way]   = '0;
    valid_o[sel_way] = 1'b1;
    tags_o[sel_way]  = tag_i;
  end

  assign flags_o.hit    = act_ok && any_hit;
  assign flags_o.miss   = act_ok && !any_hit;
  assign flags_o.evict  = act_ok && !any_hit && !any_inv;
  assign flags_o.second = (action_i == sacl_pkg::ActModify);
  assign flags_o.wr_en  = act_ok;

endmodule

// ===== hw/rtl/set_assoc_cache_lru_sim.sv =====
// Top level: set-associative cache tag store with LRU replacement and hit/miss totals.
// The set row is read into a register, then the result and strobe are registered.
// A new word is taken only after the last one is through: the set row read at the start
// edge is updated and written back in the next cycle, with no forwarding path, so busy
// covers that cycle. Reset: totals clear and the configuration returns to 4 set bits,
// 1 way, 4 offset bits; a clearing pass then zeroes all 2**MaxSetBits set rows with busy
// high. Results cannot be stalled: each strobe lasts exactly one cycle.
module set_assoc_cache_lru_sim #(
  parameter int unsigned MaxSetBits = sacl_pkg::MaxSetBitsDef,
  parameter int unsigned MaxWays    = sacl_pkg::MaxWaysDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  sacl_pkg::cmd_t                    cmd_i,
  output logic                              result_valid_o,
  output sacl_pkg::result_t                 result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sacl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sacl_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned WayW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned RecW = WayW;
  localparam int unsigned ShW  = $clog2(MaxSetBits + 1);
  localparam int unsigned RowW = MaxWays * (1 + sacl_pkg::TagW + RecW);

  // Control state.
  sacl_pkg::state_e        state_q, state_d;
  logic [MaxSetBits-1:0]   clr_q, clr_d;
  logic [2:0]              cfg_set_bits_q;
  logic [3:0]              cfg_ways_q;
  logic [3:0]              cfg_offset_q;
  logic [sacl_pkg::CntW-1:0] hits_q, hits_d;
  logic [sacl_pkg::CntW-1:0] misses_q, misses_d;
  logic [sacl_pkg::CntW-1:0] evicts_q, evicts_d;
  logic                    res_valid_q, res_valid_d;
  sacl_pkg::result_t       result_q;

  // Held word of the access in flight.
  sacl_pkg::action_e           action_q;
  logic [MaxSetBits-1:0]       set_q;
  logic [sacl_pkg::TagW-1:0]   tag_q;

  // Address split of the incoming word.
  logic                        accept;
  logic [ShW-1:0]              sb;
  logic [MaxSetBits-1:0]       set_mask;
  logic [sacl_pkg::AddrW-1:0]  rest;
  logic [sacl_pkg::AddrW-1:0]  tag_full;
  logic [MaxSetBits-1:0]       set_idx;

  // Row memory ports.
  logic                        mem_we;
  logic [MaxSetBits-1:0]       mem_waddr;
  logic [RowW-1:0]             mem_wdata;
  logic                        mem_re;
  logic [RowW-1:0]             mem_rdata;
  logic [RowW-1:0]             upd_row;

  logic [MaxWays-1:0]                        rd_valid, up_valid;
  logic [MaxWays-1:0][sacl_pkg::TagW-1:0]    rd_tags, up_tags;
  logic [MaxWays-1:0][RecW-1:0]              rd_rec, up_rec;
  sacl_pkg::acc_flags_t                      flags;

  assign busy        = (state_q != sacl_pkg::StIdle);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Clamp the set bit count to what the memory can index.
  assign sb = (32'(cfg_set_bits_q) > 32'(MaxSetBits)) ? ShW'(MaxSetBits)
                                                      : ShW'(cfg_set_bits_q);

  always_comb begin
    for (int j = 0; j < MaxSetBits; j++) begin
      set_mask[j] = (32'(j) < 32'(sb));
    end
  end

  // Drop the block offset, then take set index and tag from what remains.
  assign rest     = cmd_i.address >> cfg_offset_q;
  assign tag_full = rest >> sb;
  assign set_idx  = rest[MaxSetBits-1:0] & set_mask;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_set_bits_q <= sacl_pkg::SetBitsRst;
      cfg_ways_q     <= sacl_pkg::WaysInUseRst;
      cfg_offset_q   <= sacl_pkg::OffsetBitsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sacl_pkg::CfgSetBits:    cfg_set_bits_q <= cfg_data_i[2:0];
        sacl_pkg::CfgWaysInUse:  cfg_ways_q     <= cfg_data_i;
        sacl_pkg::CfgOffsetBits: cfg_offset_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the accepted word while its set row is read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= cmd_i.action;
      set_q    <= set_idx;
      tag_q    <= tag_full[sacl_pkg::TagW-1:0];
    end
  end

  sacl_row_mem #(
    .AddrBits (MaxSetBits),
    .DataW    (RowW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (set_idx),
    .rdata_o (mem_rdata)
  );

  // Row layout: valid bits on top, then tags, then recency ranks.
  assign {rd_valid, rd_tags, rd_rec} = mem_rdata;
  assign upd_row = {up_valid, up_tags, up_rec};

  sacl_way_logic #(
    .MaxWays (MaxWays),
    .WayW    (WayW),
    .RecW    (RecW)
  ) u_way_logic (
    .action_i      (action_q),
    .ways_in_use_i (cfg_ways_q),
    .tag_i         (tag_q),
    .valid_i       (rd_valid),
    .tags_i        (rd_tags),
    .rec_i         (rd_rec),
    .valid_o       (up_valid),
    .tags_o        (up_tags),
    .rec_o         (up_rec),
    .flags_o       (flags)
  );

  // Next totals: a modify counts its store hit first, then the load outcome.
  always_comb begin
    hits_d   = flags.second ? sacl_pkg::sat_inc(hits_q) : hits_q;
    hits_d   = flags.hit ? sacl_pkg::sat_inc(hits_d) : hits_d;
    misses_d = flags.miss ? sacl_pkg::sat_inc(misses_q) : misses_q;
    evicts_d = flags.evict ? sacl_pkg::sat_inc(evicts_q) : evicts_q;
  end

  // Sequencer: sweep rows after reset, then read, update and write back per word.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mem_we      = 1'b0;
    mem_waddr   = set_q;
    mem_wdata   = upd_row;
    mem_re      = 1'b0;
    res_valid_d = 1'b0;
    unique case (state_q)
      sacl_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + MaxSetBits'(1);
        if (&clr_q) begin
          state_d = sacl_pkg::StIdle;
        end
      end
      sacl_pkg::StIdle: begin
        if (start) begin
          mem_re  = 1'b1;
          state_d = sacl_pkg::StLookup;
        end
      end
      sacl_pkg::StLookup: begin
        mem_we      = flags.wr_en;
        res_valid_d = 1'b1;
        state_d     = sacl_pkg::StIdle;
      end
      default: begin
        state_d = sacl_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sacl_pkg::StClear;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      if (state_q == sacl_pkg::StLookup) begin
        hits_q   <= hits_d;
        misses_q <= misses_d;
        evicts_q <= evicts_d;
      end
    end
  end

  // Register the result word; its strobe is high for exactly one cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == sacl_pkg::StLookup) begin
      result_q.was_hit         <= flags.hit;
      result_q.was_miss        <= flags.miss;
      result_q.was_eviction    <= flags.evict;
      result_q.second_hit      <= flags.second;
      result_q.total_hits      <= hits_d;
      result_q.total_misses    <= misses_d;
      result_q.total_evictions <= evicts_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = result_q;

  // An accepted word yields its result strobe once its row is read and updated.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("result strobe missing after accepted word");

  // Hit and miss exclude each other; an eviction is always a miss.
  a_flags_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!(result_o.was_hit && result_o.was_miss) &&
                        (!result_o.was_eviction || result_o.was_miss)))
    else $error("inconsistent access flags");

  // Totals never go down.
  a_totals_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)) &&
         (evicts_q >= $past(evicts_q))))
    else $error("running total decreased");

endmodule

// ===== tb/tb_set_assoc_cache_lru_sim.sv =====
// Testbench for the set-associative cache tag store: random and directed accesses, LRU checks.
module tb_set_assoc_cache_lru_sim;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSets    = 1 << sacl_pkg::MaxSetBitsDef;
  localparam int unsigned NumLines   = NumSets * sacl_pkg::MaxWaysDef;
  localparam int unsigned AgeW       = $clog2(sacl_pkg::MaxWaysDef);
  localparam int unsigned PoolSize   = 12;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseWords = 190;
  localparam int unsigned CycleLimit = 400_000;
  // Register index with no register behind it; a write there must change nothing.
  localparam logic [sacl_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          start       = 1'b0;
  logic                          busy;
  sacl_pkg::cmd_t                cmd_i       = '0;
  logic                          result_valid_o;
  sacl_pkg::result_t             result_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [sacl_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [sacl_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  set_assoc_cache_lru_sim dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cmd_i,
    .result_valid_o,
    .result_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Words waiting for the block, and results the cache model has worked out.
  sacl_pkg::cmd_t    pending_cmds[$];
  sacl_pkg::result_t expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned idle_pct       = 0;
  logic        cmd_taken      = 1'b0;

  // Cache model: its own copy of the tag store, the totals and the registers.
  bit                          way_valid [NumLines];
  logic [sacl_pkg::TagW-1:0]   way_tag   [NumLines];
  logic [AgeW-1:0]             way_age   [NumLines];
  logic [sacl_pkg::CntW-1:0]   hit_count   = '0;
  logic [sacl_pkg::CntW-1:0]   miss_count  = '0;
  logic [sacl_pkg::CntW-1:0]   evict_count = '0;
  logic [2:0]                  cur_set_bits = sacl_pkg::SetBitsRst;
  logic [3:0]                  cur_ways     = sacl_pkg::WaysInUseRst;
  logic [3:0]                  cur_offset   = sacl_pkg::OffsetBitsRst;

  // Tags that random accesses draw from, so that sets fill, hit and evict.
  logic [sacl_pkg::AddrW-1:0]  tag_pool [PoolSize];

  initial begin
    for (int i = 0; i < NumLines; i++) begin
      way_valid[i] = 1'b0;
      way_tag[i]   = '0;
      way_age[i]   = '0;
    end
  end

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Make way w the most recent one of its set. Age the other valid ways that
  // were more recent, or all of them when w was just filled from invalid.
  // Ages stick at the oldest rank.
  function automatic void promote_way(int unsigned base, int unsigned nways,
                                      int unsigned w, bit filled);
    logic [AgeW-1:0] prior;
    prior = way_age[base + w];
    for (int unsigned i = 0; i < nways; i++) begin
      if (i != w && way_valid[base + i] && (filled || way_age[base + i] < prior) &&
          way_age[base + i] != AgeW'(sacl_pkg::MaxWaysDef - 1)) begin
        way_age[base + i] = way_age[base + i] + AgeW'(1);
      end
    end
    way_age[base + w] = '0;
  endfunction

  // Look one access up in the model, update it, and return the result word.
  function automatic sacl_pkg::result_t cache_access(sacl_pkg::cmd_t c);
    sacl_pkg::result_t          r;
    int unsigned                sb, nways, base, victim;
    logic [sacl_pkg::AddrW-1:0] rest;
    logic [sacl_pkg::TagW-1:0]  tg;
    logic [AgeW-1:0]            oldest;
    bit                         done;
    r      = '0;
    done   = 1'b0;
    sb     = (cur_set_bits > sacl_pkg::MaxSetBitsDef) ? sacl_pkg::MaxSetBitsDef
                                                      : cur_set_bits;
    nways  = (cur_ways == 0) ? 1 : ((cur_ways > sacl_pkg::MaxWaysDef) ? sacl_pkg::MaxWaysDef
                                                                      : cur_ways);
    if (c.action != sacl_pkg::ActNone) begin
      rest = c.address >> cur_offset;
      base = int'(rest & ((64'd1 << sb) - 64'd1)) * sacl_pkg::MaxWaysDef;
      tg   = sacl_pkg::TagW'(rest >> sb);
      // The store half of a modify always hits and counts first.
      if (c.action == sacl_pkg::ActModify) begin
        r.second_hit = 1'b1;
        hit_count    = (hit_count == '1) ? hit_count : hit_count + 1'b1;
      end
      for (int unsigned i = 0; i < nways && !done; i++) begin
        if (way_valid[base + i] && way_tag[base + i] == tg) begin
          promote_way(base, nways, i, 1'b0);
          r.was_hit = 1'b1;
          hit_count = (hit_count == '1) ? hit_count : hit_count + 1'b1;
          done      = 1'b1;
        end
      end
      if (!done) begin
        r.was_miss = 1'b1;
        miss_count = (miss_count == '1) ? miss_count : miss_count + 1'b1;
        // Fill the lowest invalid way first.
        for (int unsigned i = 0; i < nways && !done; i++) begin
          if (!way_valid[base + i]) begin
            way_valid[base + i] = 1'b1;
            way_tag[base + i]   = tg;
            promote_way(base, nways, i, 1'b1);
            done = 1'b1;
          end
        end
      end
      if (!done) begin
        // Evict the oldest way; the lowest index wins a tie.
        victim = 0;
        oldest = way_age[base];
        for (int unsigned i = 1; i < nways; i++) begin
          if (way_age[base + i] > oldest) begin
            oldest = way_age[base + i];
            victim = i;
          end
        end
        r.was_eviction = 1'b1;
        evict_count    = (evict_count == '1) ? evict_count : evict_count + 1'b1;
        way_tag[base + victim] = tg;
        promote_way(base, nways, victim, 1'b0);
      end
    end
    r.total_hits      = hit_count;
    r.total_misses    = miss_count;
    r.total_evictions = evict_count;
    return r;
  endfunction

  // Build an access that mostly lands on a few sets with pooled tags, so the
  // LRU order matters; one in ten is a fully random address.
  function automatic sacl_pkg::cmd_t random_access();
    sacl_pkg::cmd_t             c;
    int unsigned                sb;
    logic [sacl_pkg::AddrW-1:0] low_mask, set_mask, line;
    sb       = (cur_set_bits > sacl_pkg::MaxSetBitsDef) ? sacl_pkg::MaxSetBitsDef
                                                        : cur_set_bits;
    low_mask = (64'd1 << cur_offset) - 64'd1;
    set_mask = (64'd1 << sb) - 64'd1;
    c.action = ($urandom_range(99) < 5) ? sacl_pkg::ActNone
                                        : sacl_pkg::action_e'($urandom_range(2));
    if ($urandom_range(9) == 0) begin
      c.address = {$urandom(), $urandom()};
    end else begin
      line = (tag_pool[$urandom_range(PoolSize - 1)] << (sb + cur_offset)) |
             ((64'($urandom_range(3)) & set_mask) << cur_offset);
      c.address = line | ({$urandom(), $urandom()} & low_mask);
    end
    return c;
  endfunction

  task automatic queue_access(sacl_pkg::action_e act, logic [sacl_pkg::AddrW-1:0] addr);
    sacl_pkg::cmd_t c;
    c.action  = act;
    c.address = addr;
    pending_cmds.push_back(c);
  endtask

  // Write one register over the config channel and mirror it in the model.
  task automatic write_reg(logic [sacl_pkg::CfgIdxW-1:0] idx,
                           logic [sacl_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      sacl_pkg::CfgSetBits:    cur_set_bits = val[2:0];
      sacl_pkg::CfgWaysInUse:  cur_ways     = val;
      sacl_pkg::CfgOffsetBits: cur_offset   = val;
      default:                 ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every word went in and every result came back, then let the
  // pipeline drain.
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || start)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [sacl_pkg::CntW-1:0] got,
                             logic [sacl_pkg::CntW-1:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Sender: change inputs on the falling edge. Drop a word once taken, hold a
  // raised start until the block takes it, and idle at random otherwise.
  always @(negedge clk_i) begin : drive_cmds
    if (rst_ni) begin
      if (cmd_taken) void'(pending_cmds.pop_front());
      if (start && !cmd_taken) begin
        // hold the current word
      end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        cmd_i <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample on the rising edge. Check results first, then predict
  // the word taken at this same edge.
  always @(posedge clk_i) begin : watch_results
    sacl_pkg::result_t want;
    if (result_valid_o) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, actual %h", $time, result_o);
      end else begin
        want = expected_results.pop_front();
        check_field("was_hit", sacl_pkg::CntW'(result_o.was_hit),
                    sacl_pkg::CntW'(want.was_hit));
        check_field("was_miss", sacl_pkg::CntW'(result_o.was_miss),
                    sacl_pkg::CntW'(want.was_miss));
        check_field("was_eviction", sacl_pkg::CntW'(result_o.was_eviction),
                    sacl_pkg::CntW'(want.was_eviction));
        check_field("second_hit", sacl_pkg::CntW'(result_o.second_hit),
                    sacl_pkg::CntW'(want.second_hit));
        check_field("total_hits", result_o.total_hits, want.total_hits);
        check_field("total_misses", result_o.total_misses, want.total_misses);
        check_field("total_evictions", result_o.total_evictions, want.total_evictions);
      end
    end
    if (rst_ni && start && !busy) expected_results.push_back(cache_access(cmd_i));
    cmd_taken <= rst_ni && start && !busy;
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    // Register settings per phase: set bits, ways, offset bits. The list walks
    // through the extremes, saturating values and zeros among them.
    logic [sacl_pkg::CfgDataW-1:0] set_cfg [NumPhases];
    logic [sacl_pkg::CfgDataW-1:0] way_cfg [NumPhases];
    logic [sacl_pkg::CfgDataW-1:0] off_cfg [NumPhases];
    set_cfg = '{4'd4, 4'd6, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd2, 4'd5};
    way_cfg = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd15, 4'd4, 4'd8, 4'd9, 4'd3};
    off_cfg = '{4'd4, 4'd12, 4'd1, 4'd0, 4'd15, 4'd5, 4'd0, 4'd3, 4'd7};

    // Hold reset at the start; the clearing pass keeps busy high afterwards.
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        wait_idle();
        write_reg(sacl_pkg::CfgSetBits, set_cfg[p]);
        write_reg(sacl_pkg::CfgWaysInUse, way_cfg[p]);
        write_reg(sacl_pkg::CfgOffsetBits, off_cfg[p]);
        if (p == 4) write_reg(CfgUnused, sacl_pkg::CfgDataW'($urandom()));
      end
      // Sender idles a third of the time, then most of the time, then never.
      idle_pct = (p < 3) ? 33 : ((p < 6) ? 82 : 0);
      for (int i = 0; i < PoolSize; i++)
        tag_pool[i] = (i < 4) ? 64'(i) : {$urandom(), $urandom()};
      @(posedge clk_i);

      if (p == 0) begin
        // One way per set: fill, hit by every action, then conflict evictions.
        queue_access(sacl_pkg::ActLoad,   64'h0);
        queue_access(sacl_pkg::ActLoad,   64'h0);
        queue_access(sacl_pkg::ActStore,  64'hF);
        queue_access(sacl_pkg::ActModify, 64'h0);
        queue_access(sacl_pkg::ActLoad,   64'h100);
        queue_access(sacl_pkg::ActModify, 64'h200);
        // An unused action leaves the store alone and reports the totals.
        queue_access(sacl_pkg::ActNone,   '1);
        queue_access(sacl_pkg::ActLoad,   '1);
        queue_access(sacl_pkg::ActStore,  '1);
        queue_access(sacl_pkg::ActLoad,   64'h8000_0000_0000_0000);
        queue_access(sacl_pkg::ActLoad,   64'h7FFF_FFFF_FFFF_FFFF);
        queue_access(sacl_pkg::ActStore,  64'h10);
      end else if (p == 3) begin
        // No offset and a single set: the top two address bits fall off the tag, so
        // the first three addresses alias onto one line and the last two onto another.
        queue_access(sacl_pkg::ActLoad,   64'h0);
        queue_access(sacl_pkg::ActLoad,   64'h4000_0000_0000_0000);
        queue_access(sacl_pkg::ActModify, 64'h8000_0000_0000_0000);
        queue_access(sacl_pkg::ActLoad,   64'h3FFF_FFFF_FFFF_FFFF);
        queue_access(sacl_pkg::ActStore,  '1);
      end

      for (int n = 0; n < PhaseWords; n++) pending_cmds.push_back(random_access());
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
